// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Implication into the next cycle, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Implication into the next cycle, checked during reset as well
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/lipg_pkg.sv =====
// Types, codes and the heartbeat duty table of the indicator pattern generator.
// Depends on nothing.
`default_nettype none
package lipg_pkg;

  // Commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Mode codes
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_ON    = 3'd1;
  localparam logic [2:0] MODE_FLASH = 3'd2;
  localparam logic [2:0] MODE_FADE  = 3'd3;
  localparam logic [2:0] MODE_HEART = 3'd4;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Register indexes
  localparam logic CFG_BLINK_INC = 1'b0;
  localparam logic CFG_RAMP_INC  = 1'b1;

  // Constants
  localparam logic [6:0] DUTY_FULL      = 7'd100;
  localparam logic [7:0] CNT_FULL       = 8'd100;
  localparam logic [7:0] FLASH_LEVEL    = 8'd50;
  localparam logic [7:0] HEART_WRAP     = 8'd180;
  localparam logic [7:0] STEP_ON_CHANGE = 8'd10;
  localparam logic [6:0] STEP_RESET     = 7'd10;

  // Architectural state carried from item to item
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] cnt;
    logic [7:0] step;
    logic [6:0] duty;
  } state_t;

  // Heartbeat duty at a table point; other counter values hold the duty
  function automatic logic [6:0] heart_duty(input logic [7:0] cnt, input logic [6:0] held);
    logic [6:0] d;
    d = held;
    case (cnt)
      8'd0:    d = 7'd25;
      8'd10:   d = 7'd50;
      8'd20:   d = 7'd100;
      8'd40:   d = 7'd50;
      8'd50:   d = 7'd0;
      8'd60:   d = 7'd50;
      8'd70:   d = 7'd100;
      8'd80:   d = 7'd75;
      8'd90:   d = 7'd50;
      8'd100:  d = 7'd25;
      8'd110:  d = 7'd0;
      default: d = held;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lipg_update.sv =====
// Next-state and result logic for one item of the indicator pattern generator.
// Depends on lipg_pkg.
`default_nettype none
module lipg_update (
  input  wire                   cmd,
  input  wire [2:0]             new_mode,
  input  wire [6:0]             blink_inc,
  input  wire [6:0]             ramp_inc,
  input  lipg_pkg::state_t      cur,
  output lipg_pkg::state_t      nxt,
  output logic                  status
);
  import lipg_pkg::*;

  logic [6:0] tri_reg;
  logic [7:0] tri_step;
  logic [7:0] cnt_sum;
  logic [7:0] heart_sum;

  // Pick the step register of the triangle modes
  assign tri_reg = (cur.mode == MODE_FLASH) ? blink_inc : ramp_inc;

  // Turn the triangle around at its ends
  always_comb begin
    tri_step = cur.step;
    if (cur.cnt == CNT_FULL) begin
      tri_step = 8'd0 - {1'b0, tri_reg};
    end
    if (cur.cnt == 8'd0) begin
      tri_step = {1'b0, tri_reg};
    end
  end

  assign cnt_sum   = cur.cnt + tri_step;
  assign heart_sum = cur.cnt + cur.step;

  // Apply a tick or a mode request
  always_comb begin
    nxt    = cur;
    status = STATUS_OK;
    if (cmd == CMD_TICK) begin
      case (cur.mode)
        MODE_ON: begin
          nxt.duty = DUTY_FULL;
        end
        MODE_FLASH: begin
          nxt.step = tri_step;
          nxt.duty = (cur.cnt >= FLASH_LEVEL) ? DUTY_FULL : 7'd0;
          nxt.cnt  = cnt_sum;
        end
        MODE_FADE: begin
          nxt.step = tri_step;
          nxt.cnt  = cnt_sum;
          nxt.duty = (cnt_sum > CNT_FULL) ? DUTY_FULL : cnt_sum[6:0];
        end
        MODE_HEART: begin
          if (heart_sum == HEART_WRAP) begin
            nxt.cnt = 8'd0;
          end else begin
            nxt.cnt  = heart_sum;
            nxt.duty = heart_duty(heart_sum, cur.duty);
          end
        end
        default: begin
          nxt.duty = 7'd0;
        end
      endcase
    end else if (new_mode > MODE_HEART) begin
      status = STATUS_BAD;
    end else if (new_mode != cur.mode) begin
      nxt.mode = new_mode;
      nxt.step = STEP_ON_CHANGE;
      nxt.cnt  = 8'd0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/led_indication_pattern_generator.sv =====
// Indicator duty pattern generator: off, on, flash, fade and heartbeat modes.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while out_stall does not hold the result; the
// state updates in the single compute stage, so items follow back to back.
// Reset (rst_n low, synchronous): mode off, counter, step and duty zero,
// both step registers 10, pipeline empty.
`default_nettype none
module led_indication_pattern_generator (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_cmd,
  input  wire [2:0]  in_new_mode,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [6:0] out_duty,
  output logic       out_status,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [6:0]  cfg_wdata
);
  import lipg_pkg::*;

  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [2:0] s1_mode_r;
  logic [6:0] blink_inc_r;
  logic [6:0] ramp_inc_r;
  state_t     state_r;
  state_t     state_nxt;
  logic       status_nxt;
  logic       advance;

  // Move the held item forward when the result register is free
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_inc_r <= STEP_RESET;
      ramp_inc_r  <= STEP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BLINK_INC) begin
        blink_inc_r <= cfg_wdata;
      end else begin
        ramp_inc_r <= cfg_wdata;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r  <= in_cmd;
      s1_mode_r <= in_new_mode;
    end
  end

  lipg_update u_update (
    .cmd        (s1_cmd_r),
    .new_mode   (s1_mode_r),
    .blink_inc  (blink_inc_r),
    .ramp_inc   (ramp_inc_r),
    .cur        (state_r),
    .nxt        (state_nxt),
    .status     (status_nxt)
  );

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_status <= status_nxt;
    end
  end

  assign out_duty = state_r.duty;

endmodule
`default_nettype wire

// ===== rtl/lipg_checker.sv =====
// Port-level checks of the indicator pattern generator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lipg_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [6:0] out_duty,
  input wire       out_status
);

  // Reset empties the result register
  `ASSERT_NXT_ALL(a_reset_empty, clk, !rst_n, !out_valid)

  // Duty never exceeds full scale
  `ASSERT_IMP(a_duty_range, clk, rst_n, out_valid, out_duty <= 7'd100)

  // An empty result register never stalls the input
  `ASSERT_IMP(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

  // A stalled item holds
  `ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
              out_valid && $stable(out_duty) && $stable(out_status))

endmodule

bind led_indication_pattern_generator lipg_checker u_lipg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_duty   (out_duty),
  .out_status (out_status)
);
`default_nettype wire
